// File: rtl/sfe_pkg.sv
package sfe_pkg;

    // Length limits of the header and of the delimiter, in bytes
    localparam int MAX_HEADER_BYTES = 8;
    localparam int MAX_DELIM_BYTES  = 8;

    // Frame size limit used when max_frame_len is zero
    localparam logic [31:0] DEFAULT_MAX_FRAME = 32'd10485760;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAMING_MODE      = 3'd0;
    localparam logic [2:0] REG_HEADER_BYTES      = 3'd1;
    localparam logic [2:0] REG_MAX_FRAME_LEN     = 3'd2;
    localparam logic [2:0] REG_DELIMITER_LEN     = 3'd3;
    localparam logic [2:0] REG_DELIMITER_PATTERN = 3'd4;

    // Framing modes
    localparam logic MODE_LENGTH    = 1'b0;
    localparam logic MODE_DELIMITER = 1'b1;

    // Input kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_LEN = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_BODY = 2'd1,
        PH_ERR  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       frame_last;
        logic [1:0] frame_status;
    } result_t;

    // Mask that keeps the low nbytes bytes of a 64-bit word (nbytes 0..8)
    function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < nbytes) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/stream_frame_extractor.sv
// stream_frame_extractor: length-prefix / delimiter deframer, one byte per request.
// A result is registered in the output register, or in the skid entry if that is held.
// Throughput: one input request per cycle while the skid entry is empty; a two-entry
// output stage (register plus skid) keeps input accepted while one result waits.
// Reset (rst_n, asynchronous, active low): registers return to their defaults,
// framing state goes to header phase with empty counters and window, outputs empty.
module stream_frame_extractor (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] kind
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] payload_byte
    output logic        m_tlast,   // frame_last
    output logic [2:0]  m_tuser    // [0] byte_valid, [2:1] frame_status
);
    import sfe_pkg::*;

    // configuration registers
    logic        framing_mode_reg;
    logic [3:0]  header_bytes_reg;
    logic [31:0] max_frame_len_reg;
    logic [3:0]  delimiter_len_reg;
    logic [63:0] delimiter_pattern_reg;

    // framing state
    phase_t      phase_reg,         phase_next;
    logic [3:0]  header_count_reg,  header_count_next;
    logic [63:0] frame_length_reg,  frame_length_next;
    logic [32:0] payload_count_reg, payload_count_next;
    logic [55:0] delim_window_reg,  delim_window_next;
    logic [2:0]  window_fill_reg,   window_fill_next;

    // output stage
    result_t     main_reg, skid_reg;
    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    logic        accept;
    logic        take;
    logic        res_hit;
    result_t     res;

    // working values
    logic [31:0] maxf;
    logic [3:0]  hb;
    logic [3:0]  dl;
    logic [2:0]  dl_m1;
    logic [2:0]  fill;
    logic [3:0]  fill_p1;
    logic [63:0] cand;
    logic [63:0] len_shift;
    logic [3:0]  hc_inc;
    logic [32:0] pc_inc;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = main_valid_reg && m_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            framing_mode_reg      <= MODE_LENGTH;
            header_bytes_reg      <= 4'd4;
            max_frame_len_reg     <= 32'd0;
            delimiter_len_reg     <= 4'd1;
            delimiter_pattern_reg <= 64'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAMING_MODE:      framing_mode_reg      <= cfg_wdata[0];
                REG_HEADER_BYTES:      header_bytes_reg      <= cfg_wdata[3:0];
                REG_MAX_FRAME_LEN:     max_frame_len_reg     <= cfg_wdata[31:0];
                REG_DELIMITER_LEN:     delimiter_len_reg     <= cfg_wdata[3:0];
                REG_DELIMITER_PATTERN: delimiter_pattern_reg <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    // clamped lengths and effective frame limit
    always_comb
    begin
        maxf = (max_frame_len_reg == 32'd0) ? DEFAULT_MAX_FRAME : max_frame_len_reg;

        if (header_bytes_reg == 4'd0)
            hb = 4'd1;
        else if (header_bytes_reg > 4'(MAX_HEADER_BYTES))
            hb = 4'(MAX_HEADER_BYTES);
        else
            hb = header_bytes_reg;

        if (delimiter_len_reg == 4'd0)
            dl = 4'd1;
        else if (delimiter_len_reg > 4'(MAX_DELIM_BYTES))
            dl = 4'(MAX_DELIM_BYTES);
        else
            dl = delimiter_len_reg;

        dl_m1   = 3'(dl - 4'd1);
        fill    = (window_fill_reg > dl_m1) ? dl_m1 : window_fill_reg;
        fill_p1 = {1'b0, fill} + 4'd1;
        cand    = ({delim_window_reg, 8'h00} | {56'd0, s_tdata}) & byte_mask(fill_p1);
        len_shift = (header_count_reg != 4'd0) ? {frame_length_reg[55:0], s_tdata}
                                               : {56'd0, s_tdata};
        hc_inc  = header_count_reg + 4'd1;
        pc_inc  = payload_count_reg + 33'd1;
    end

    // next framing state and the result of the accepted byte
    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        delim_window_next  = delim_window_reg;
        window_fill_next   = window_fill_reg;
        res_hit            = 1'b0;
        res                = '0;

        if (accept)
        begin
            if (s_tuser == KIND_CLEAR)
            begin
                phase_next         = PH_HEAD;
                header_count_next  = 4'd0;
                frame_length_next  = 64'd0;
                payload_count_next = 33'd0;
                delim_window_next  = 56'd0;
                window_fill_next   = 3'd0;
            end
            else if (phase_reg == PH_ERR)
            begin
                // sticky error: bytes are dropped
            end
            else if (framing_mode_reg == MODE_LENGTH)
            begin
                if (phase_reg == PH_HEAD)
                begin
                    frame_length_next = len_shift;
                    header_count_next = hc_inc;
                    if (hc_inc >= hb)
                    begin
                        header_count_next = 4'd0;
                        if (len_shift == 64'd0)
                        begin
                            phase_next       = PH_ERR;
                            res_hit          = 1'b1;
                            res.frame_last   = 1'b1;
                            res.frame_status = ST_ZERO_LEN;
                        end
                        else if (len_shift > {32'd0, maxf})
                        begin
                            phase_next       = PH_ERR;
                            res_hit          = 1'b1;
                            res.frame_last   = 1'b1;
                            res.frame_status = ST_OVERSIZE;
                        end
                        else
                        begin
                            phase_next         = PH_BODY;
                            payload_count_next = 33'd0;
                        end
                    end
                end
                else
                begin
                    // payload byte passes through
                    res_hit            = 1'b1;
                    res.payload_byte   = s_tdata;
                    res.byte_valid     = 1'b1;
                    payload_count_next = pc_inc;
                    if ({31'd0, pc_inc} >= frame_length_reg)
                    begin
                        phase_next         = PH_HEAD;
                        payload_count_next = 33'd0;
                        res.frame_last     = 1'b1;
                    end
                end
            end
            else
            begin
                if (fill_p1 < dl)
                begin
                    // window still filling
                    delim_window_next = cand[55:0];
                    window_fill_next  = fill_p1[2:0];
                end
                else if (cand == (delimiter_pattern_reg & byte_mask(dl)))
                begin
                    delim_window_next  = 56'd0;
                    window_fill_next   = 3'd0;
                    payload_count_next = 33'd0;
                    phase_next         = PH_HEAD;
                    res_hit            = 1'b1;
                    res.frame_last     = 1'b1;
                end
                else if (payload_count_reg >= {1'b0, maxf})
                begin
                    phase_next       = PH_ERR;
                    res_hit          = 1'b1;
                    res.frame_last   = 1'b1;
                    res.frame_status = ST_OVERSIZE;
                end
                else
                begin
                    // oldest held byte cannot start a match: pass it on
                    payload_count_next = pc_inc;
                    delim_window_next  = 56'(cand & byte_mask({1'b0, dl_m1}));
                    window_fill_next   = dl_m1;
                    res_hit            = 1'b1;
                    res.payload_byte   = cand[{dl_m1, 3'b000} +: 8];
                    res.byte_valid     = 1'b1;
                end
            end
        end
    end

    // framing state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEAD;
            header_count_reg  <= 4'd0;
            frame_length_reg  <= 64'd0;
            payload_count_reg <= 33'd0;
            delim_window_reg  <= 56'd0;
            window_fill_reg   <= 3'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            delim_window_reg  <= delim_window_next;
            window_fill_reg   <= window_fill_next;
        end
    end

    // output stage occupancy
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
                skid_valid_next = 1'b0;
        end
        else if (res_hit)
        begin
            if (!main_valid_reg || take)
                main_valid_next = 1'b1;
            else
                skid_valid_next = 1'b1;
        end
        else if (take)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // output stage data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                main_reg <= skid_reg;
        end
        else if (res_hit)
        begin
            if (!main_valid_reg || take)
                main_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_reg.payload_byte;
    assign m_tlast  = main_reg.frame_last;
    assign m_tuser  = {main_reg.frame_status, main_reg.byte_valid};

endmodule
